### design/sgm_pkg.sv
package sgm_pkg;

	// defaults for the frame store sizing
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// field widths fixed by the interface
	localparam int PIX_W     = 8;
	localparam int LUMA_W    = 16;
	localparam int COL_W     = 10;
	localparam int ROW_W     = 12;
	localparam int MAG_W     = 19;
	localparam int GRAD_W    = 20;
	localparam int SQ_W      = 38;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 13;
	localparam int WCFG_W    = 11;
	localparam int HCFG_W    = 13;

	// luma weights, Q0.8
	localparam logic [7:0] LUMA_KR = 8'd77;
	localparam logic [7:0] LUMA_KG = 8'd150;
	localparam logic [7:0] LUMA_KB = 8'd29;

	// square root: one result bit per step
	localparam int ISQRT_STEPS = SQ_W / 2;
	localparam int ISQRT_CNT_W = $clog2(ISQRT_STEPS + 1);
	localparam int ISQRT_REM_W = MAG_W + 3;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_MONO_MODE    = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic [MAG_W-1:0] magnitude;
		logic             last;
	} result_t;

	// work handed from front to back
	typedef struct packed {
		logic [SQ_W-1:0]  sq;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             last;
	} work_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_READ,
		F_SQUARE,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CALC,
		B_HOLD
	} back_state_t;

endpackage

### design/sgm_ram.sv
module sgm_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/sgm_front.sv
module sgm_front #(
	parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sgm_pkg::WCFG_W-1:0]    image_width,
	input  logic [sgm_pkg::HCFG_W-1:0]    image_height,
	input  logic                          mono_mode,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sgm_pkg::pixel_t               in_data,
	output logic                          push_valid,
	input  logic                          push_ready,
	output sgm_pkg::work_t                push_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int LW = sgm_pkg::LUMA_W;
	localparam int GW = sgm_pkg::GRAD_W;

	sgm_pkg::front_state_t state_q, state_d;

	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [LW-1:0]   luma_q;
	logic [LW-1:0]   win_q [6];
	logic [LW-1:0]   top_rd, mid_rd;
	logic            accept;
	logic [31:0]     w32, h32;

	logic signed [GW-1:0]   gx_s1, gy_s1;
	logic                   emit_s1, emit_s2;
	logic [sgm_pkg::COL_W-1:0] col_s1, col_s2;
	logic [sgm_pkg::ROW_W-1:0] row_s1, row_s2;
	logic                   last_s1, last_s2;
	logic [2*GW-1:0]        sqx_s2, sqy_s2;

	logic [LW-1:0]        luma_d;
	logic signed [GW-1:0] lt, lm, lb, ct, cb, rt, rm, rb;
	logic [31:0]          col32, row32, colm1, rowm1;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == sgm_pkg::F_IDLE);

	// clamp frame size to the supported range
	always_comb begin
		if (image_width < sgm_pkg::WCFG_W'(3)) begin
			w32 = 32'd3;
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end else begin
			w32 = 32'(image_width);
		end
		if (image_height < sgm_pkg::HCFG_W'(3)) begin
			h32 = 32'd3;
		end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
			h32 = 32'(MAX_HEIGHT);
		end else begin
			h32 = 32'(image_height);
		end
	end

	// luma conversion
	always_comb begin
		if (mono_mode) begin
			luma_d = {in_data.red, 8'd0};
		end else begin
			luma_d = LW'(in_data.red) * LW'(sgm_pkg::LUMA_KR)
				+ LW'(in_data.green) * LW'(sgm_pkg::LUMA_KG)
				+ LW'(in_data.blue) * LW'(sgm_pkg::LUMA_KB);
		end
	end

	// line stores, read on accept, written in the following cycle
	sgm_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (state_q == sgm_pkg::F_READ),
		.waddr (col_q),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (top_rd)
	);

	sgm_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (state_q == sgm_pkg::F_READ),
		.waddr (col_q),
		.wdata (luma_q),
		.re    (accept),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	// window taps, zero-extended to signed
	always_comb begin
		lt = $signed({4'd0, win_q[0]});
		lm = $signed({4'd0, win_q[1]});
		lb = $signed({4'd0, win_q[2]});
		ct = $signed({4'd0, win_q[3]});
		cb = $signed({4'd0, win_q[5]});
		rt = $signed({4'd0, top_rd});
		rm = $signed({4'd0, mid_rd});
		rb = $signed({4'd0, luma_q});
		col32 = 32'(col_q);
		row32 = 32'(row_q);
		colm1 = col32 - 32'd1;
		rowm1 = row32 - 32'd1;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgm_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d    = state_q;
		push_valid = 1'b0;
		case (state_q)
			sgm_pkg::F_IDLE: begin
				if (accept) begin
					state_d = sgm_pkg::F_READ;
				end
			end
			sgm_pkg::F_READ: begin
				state_d = sgm_pkg::F_SQUARE;
			end
			sgm_pkg::F_SQUARE: begin
				state_d = sgm_pkg::F_PUSH;
			end
			sgm_pkg::F_PUSH: begin
				push_valid = emit_s2;
				if (!emit_s2 || push_ready) begin
					state_d = sgm_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = sgm_pkg::F_IDLE;
			end
		endcase
	end

	assign push_data.sq     = sgm_pkg::SQ_W'(sqx_s2) + sgm_pkg::SQ_W'(sqy_s2);
	assign push_data.column = col_s2;
	assign push_data.row    = row_s2;
	assign push_data.last   = last_s2;

	// counters and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			emit_s1 <= 1'b0;
			emit_s2 <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (state_q == sgm_pkg::F_READ) begin
			emit_s1  <= (col32 >= 32'd2) && (row32 >= 32'd2);
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_rd;
			win_q[4] <= mid_rd;
			win_q[5] <= luma_q;
			if (col32 + 32'd1 >= w32) begin
				col_q <= '0;
				if (row32 + 32'd1 >= h32) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end else if (state_q == sgm_pkg::F_SQUARE) begin
			emit_s2 <= emit_s1;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (accept) begin
			luma_q <= luma_d;
		end
		if (state_q == sgm_pkg::F_READ) begin
			gx_s1   <= (rt + (rm <<< 1) + rb) - (lt + (lm <<< 1) + lb);
			gy_s1   <= (lb + (cb <<< 1) + rb) - (lt + (ct <<< 1) + rt);
			col_s1  <= colm1[sgm_pkg::COL_W-1:0];
			row_s1  <= rowm1[sgm_pkg::ROW_W-1:0];
			last_s1 <= (col32 == w32 - 32'd1) && (row32 == h32 - 32'd1);
		end
		if (state_q == sgm_pkg::F_SQUARE) begin
			// squares at full product width
			sqx_s2  <= $unsigned((2*GW)'(gx_s1) * (2*GW)'(gx_s1));
			sqy_s2  <= $unsigned((2*GW)'(gy_s1) * (2*GW)'(gy_s1));
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			last_s2 <= last_s1;
		end
	end

endmodule

### design/sgm_queue.sv
module sgm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  sgm_pkg::work_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output sgm_pkg::work_t pop_data
);

	sgm_pkg::work_t mem_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### design/sgm_back.sv
module sgm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  sgm_pkg::work_t   pop_data,
	output logic             out_valid,
	input  logic             out_ready,
	output sgm_pkg::result_t out_data
);

	localparam int RMW = sgm_pkg::ISQRT_REM_W;
	localparam int MW  = sgm_pkg::MAG_W;
	localparam int SW  = sgm_pkg::SQ_W;

	sgm_pkg::back_state_t state_q, state_d;

	logic [SW-1:0]   rad_q;
	logic [RMW-1:0]  rem_q;
	logic [MW-1:0]   root_q;
	logic [sgm_pkg::ISQRT_CNT_W-1:0] cnt_q;
	logic [sgm_pkg::COL_W-1:0] col_q;
	logic [sgm_pkg::ROW_W-1:0] row_q;
	logic            last_q;
	logic            out_valid_q;
	sgm_pkg::result_t out_q;

	logic [RMW-1:0]  rem_sh, trial;
	logic            fits, calc_done, out_free, load_out;

	// one root bit per step
	always_comb begin
		rem_sh = {rem_q[RMW-3:0], rad_q[SW-1:SW-2]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = (rem_sh >= trial);
	end

	assign calc_done = (cnt_q == sgm_pkg::ISQRT_CNT_W'(sgm_pkg::ISQRT_STEPS - 1));
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgm_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			sgm_pkg::B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = sgm_pkg::B_CALC;
				end
			end
			sgm_pkg::B_CALC: begin
				if (calc_done) begin
					state_d = sgm_pkg::B_HOLD;
				end
			end
			sgm_pkg::B_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = sgm_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = sgm_pkg::B_IDLE;
			end
		endcase
	end

	// output register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == sgm_pkg::B_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == sgm_pkg::B_CALC) begin
				cnt_q <= cnt_q + sgm_pkg::ISQRT_CNT_W'(1);
			end
		end
	end

	// square root datapath
	always_ff @(posedge clk) begin
		if (state_q == sgm_pkg::B_IDLE && pop_valid) begin
			rad_q  <= pop_data.sq;
			rem_q  <= '0;
			root_q <= '0;
			col_q  <= pop_data.column;
			row_q  <= pop_data.row;
			last_q <= pop_data.last;
		end else if (state_q == sgm_pkg::B_CALC) begin
			rad_q <= {rad_q[SW-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[MW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[MW-2:0], 1'b0};
			end
		end
		if (load_out) begin
			out_q.column    <= col_q;
			out_q.row       <= row_q;
			out_q.magnitude <= root_q;
			out_q.last      <= last_q;
		end
	end

endmodule

### design/sobel_gradient_magnitude_core.sv
// Path: a pixel that completes a 3x3 window passes 3 front stages, the queue,
// 19 square root steps, the output load and the output register before its
// result beat can be taken.
// Flow: the front takes a new pixel only once it is done with the last one; results
// leave one at a time, set by the shared bit-serial square root unit.
// Reset (arst_n, async, low): clears counters, window, queue and handshakes;
// registers return to 640 x 480 RGB; line store contents stay undefined.
module sobel_gradient_magnitude_core #(
	parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sgm_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sgm_pkg::pixel_t               in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sgm_pkg::result_t              out_data
);

	logic [sgm_pkg::WCFG_W-1:0] width_q;
	logic [sgm_pkg::HCFG_W-1:0] height_q;
	logic                       mono_q;

	logic           push_valid, push_ready, pop_valid, pop_ready;
	sgm_pkg::work_t push_data, pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sgm_pkg::WCFG_W'(640);
			height_q <= sgm_pkg::HCFG_W'(480);
			mono_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				sgm_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[sgm_pkg::WCFG_W-1:0];
				sgm_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[sgm_pkg::HCFG_W-1:0];
				sgm_pkg::CFG_MONO_MODE:    mono_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sgm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (width_q),
		.image_height (height_q),
		.mono_mode    (mono_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	sgm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sgm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### design/sgm_checker.sv
module sgm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input sgm_pkg::result_t out_data
);

	// a stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result beat changed while stalled");

	// window centers are never on the first row or column
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.column != '0 && out_data.row != '0)
		else $error("border pixel emitted");

	// the front works one pixel at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pixel accepted while front busy");

endmodule

bind sobel_gradient_magnitude_core sgm_checker u_sgm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

### verif/sobel_gradient_magnitude_checker.sv
`timescale 1ns / 1ps

module sobel_gradient_magnitude_checker
	import sgm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  pixel_t               in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  result_t              out_data,
	output int                   failures,
	output int                   pending
);

	localparam int ROW_CAP = 1024;
	localparam int COL_CAP = 4096;

	// shadow of the block's pixel pipeline
	logic [LUMA_W-1:0] upper_line [ROW_CAP];
	logic [LUMA_W-1:0] middle_line [ROW_CAP];
	logic [LUMA_W-1:0] win [6];
	int unsigned       col_pos;
	int unsigned       row_pos;
	int unsigned       width_reg;
	int unsigned       height_reg;
	bit                mono_reg;
	result_t           gradient_q[$];

	assign pending = gradient_q.size();

	function automatic int unsigned clip_dim(int unsigned v, int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	// floor square root, one result bit at a time from the top
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 19; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v) root = trial;
		end
		return root;
	endfunction

	// advance the shadow by one pixel; queue the gradient if the window is interior
	task automatic take_pixel(pixel_t p);
		int unsigned       w, h, c;
		logic [LUMA_W-1:0] luma, top, mid;
		longint            gx, gy;
		result_t           r;
		w = clip_dim(width_reg, ROW_CAP);
		h = clip_dim(height_reg, COL_CAP);
		c = col_pos % ROW_CAP;
		if (mono_reg) luma = {p.red, 8'd0};
		else luma = 16'(77 * p.red + 150 * p.green + 29 * p.blue);
		top = upper_line[c];
		mid = middle_line[c];
		if (col_pos >= 2 && row_pos >= 2) begin
			gx = (longint'(top) + 2 * longint'(mid) + longint'(luma))
				- (longint'(win[0]) + 2 * longint'(win[1]) + longint'(win[2]));
			gy = (longint'(win[2]) + 2 * longint'(win[5]) + longint'(luma))
				- (longint'(win[0]) + 2 * longint'(win[3]) + longint'(top));
			r.column    = COL_W'(col_pos - 1);
			r.row       = ROW_W'(row_pos - 1);
			r.magnitude = MAG_W'(floor_root(longint'(gx * gx + gy * gy)));
			r.last      = (col_pos == w - 1) && (row_pos == h - 1);
			gradient_q.push_back(r);
		end
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = top;
		win[4] = mid;
		win[5] = luma;
		upper_line[c]  = mid;
		middle_line[c] = luma;
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			if (row_pos + 1 >= h) row_pos = 0;
			else row_pos++;
		end else begin
			col_pos++;
		end
	endtask

	initial begin
		failures = 0;
		col_pos = 0;
		row_pos = 0;
		width_reg = 640;
		height_reg = 480;
		mono_reg = 0;
		foreach (win[i]) win[i] = '0;
		foreach (upper_line[i]) begin
			upper_line[i]  = '0;
			middle_line[i] = '0;
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			// result beat against the oldest gradient
			if (out_valid && out_ready) begin
				if (gradient_q.size() == 0) begin
					$error("result beat with nothing expected: %p", out_data);
					failures++;
				end else begin
					e = gradient_q.pop_front();
					if (out_data.column !== e.column) begin
						$error("column: expected %0d, got %0d", e.column, out_data.column);
						failures++;
					end
					if (out_data.row !== e.row) begin
						$error("row: expected %0d, got %0d", e.row, out_data.row);
						failures++;
					end
					if (out_data.magnitude !== e.magnitude) begin
						$error("magnitude: expected %0d, got %0d",
							e.magnitude, out_data.magnitude);
						failures++;
					end
					if (out_data.last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, out_data.last);
						failures++;
					end
				end
			end
			// register writes
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_IMAGE_WIDTH:  width_reg  = cfg_data[WCFG_W-1:0];
					CFG_IMAGE_HEIGHT: height_reg = cfg_data[HCFG_W-1:0];
					CFG_MONO_MODE:    mono_reg   = cfg_data[0];
					default: ;
				endcase
			end
			// pixel beat
			if (in_valid && in_ready) take_pixel(in_data);
		end
	end

endmodule

### verif/sobel_gradient_magnitude_core_tb.sv
`timescale 1ns / 1ps

module sobel_gradient_magnitude_core_tb;
	import sgm_pkg::*;

	localparam int QUIET_LIMIT = 6000;
	localparam int SETTLE      = 60;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	pixel_t               in_data;
	logic                 out_valid;
	logic                 out_ready;
	result_t              out_data;
	int                   failures;
	int                   pending;
	int                   quiet_cycles;
	bit                   calm;
	bit                   hold_out;

	sobel_gradient_magnitude_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	sobel_gradient_magnitude_checker gradient_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.failures(failures), .pending(pending)
	);

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// result side: random back-pressure, plus one long hold on request
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				hold_out = 0;
			end
			out_ready <= calm || ($urandom_range(99) >= 24);
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_pixel(pixel_t p);
		if (!calm && $urandom_range(99) < 24) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		in_data  <= p;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
	endtask

	// drop valid at the accepting edge, then wait for every result
	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, int unsigned val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= CFG_DAT_W'(val);
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic set_frame(int unsigned w, int unsigned h, int unsigned mono);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_MONO_MODE, mono);
	endtask

	function automatic pixel_t random_pixel(int unsigned flavor);
		pixel_t p;
		if (flavor == 0) begin
			p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
			p.green = $urandom_range(1) ? 8'hFF : 8'h00;
			p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
		end else begin
			p = pixel_t'(24'($urandom));
		end
		return p;
	endfunction

	task automatic send_random(int unsigned count);
		int unsigned flavor;
		flavor = $urandom_range(3);
		for (int i = 0; i < count; i++) send_pixel(random_pixel(flavor));
	endtask

	initial begin
		arst_n    = 0;
		cfg_we    = 0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 0;
		in_data   = '0;
		calm      = 0;
		hold_out  = 0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n = 1;
		@(posedge clk);

		// smallest frame, extreme pixels: flat, step edges, all-ones
		set_frame(3, 3, 0);
		send_pixel('{8'hFF, 8'hFF, 8'hFF});
		send_pixel('{8'h00, 8'h00, 8'h00});
		send_pixel('{8'hFF, 8'hFF, 8'hFF});
		send_pixel('{8'hFF, 8'h00, 8'h00});
		send_pixel('{8'h00, 8'hFF, 8'h00});
		send_pixel('{8'h00, 8'h00, 8'hFF});
		send_pixel('{8'h00, 8'h00, 8'h00});
		send_pixel('{8'h00, 8'h00, 8'h00});
		send_pixel('{8'hFF, 8'hFF, 8'hFF});
		drain();

		// mono: green and blue must not matter
		set_frame(4, 4, 1);
		for (int i = 0; i < 16; i++)
			send_pixel('{(i % 3 == 0) ? 8'hFF : 8'h00, 8'($urandom), 8'($urandom)});
		drain();

		// widest row, width above the limit is clipped; fills every line entry
		set_frame(2047, 3, 0);
		send_random(1030);
		drain();

		// width below the limit clipped, height above it clipped; block backs up
		calm = 1;
		set_frame(0, 8191, 1);
		send_random(300);
		drain();
		calm = 0;

		// long hold on the result side while pixels keep coming
		set_frame(5, 4, 0);
		hold_out = 1;
		send_random(200);
		drain();

		// assorted small frames, clipped sizes among them
		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 3);
			set_frame($urandom_range(0, 9), $urandom_range(0, 7), $urandom_range(1));
			send_random(30);
			if (ph == 5) drain();
			send_random(30);
			drain();
		end
		calm = 0;

		if (failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
